[hdl/tss_pkg.sv]
package tss_pkg;

   localparam int unsigned WAIT_TIMEOUT = 2000;
   localparam int unsigned FULL_SCALE = 10000;

   localparam int unsigned THR_W = 14;
   localparam int unsigned TIME_W = 16;
   localparam int unsigned TIMER_W = 17;
   localparam int unsigned IDX_W = 16;
   localparam int unsigned PROD_W = THR_W + IDX_W;
   localparam int unsigned DVD_W = THR_W + 2;
   localparam int unsigned DIV_STEPS = DVD_W;
   localparam int unsigned CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [THR_W-1:0] FULL_SCALE_V = THR_W'(FULL_SCALE);
   localparam logic [TIMER_W-1:0] WAIT_TIMEOUT_V = TIMER_W'(WAIT_TIMEOUT);
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
   localparam logic [IDX_W-1:0] IDX_MAX = '1;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_SETTLE = 2'd1;
   localparam logic [1:0] PH_MEASURE = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [1:0] MODE_DWELL = 2'd0;
   localparam logic [1:0] MODE_WINDOW = 2'd1;

   localparam logic KIND_HOLD = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_KIND = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_START = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_END = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_INC = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REC = 3'd7;

   typedef struct packed {
      logic cmd;
      logic motor_at_target;
      logic recorder_busy;
   } req_word_type;

   typedef struct packed {
      logic [THR_W-1:0] throttle_cmd;
      logic throttle_write;
      logic [1:0] phase_now;
      logic trigger_measure;
      logic stop_recorder;
      logic wait_timed_out;
      logic point_done;
      logic step_done;
      logic [IDX_W-1:0] point_number;
   } rsp_word_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic div_step;
      logic mul;
      logic upd;
      logic load_out;
   } tss_cmd_type;

   typedef struct packed {
      logic need_div;
      logic need_mul;
      logic div_last;
   } tss_sts_type;

   function automatic logic [THR_W-1:0] clamp_fs(input logic [THR_W-1:0] v);
      return (v > FULL_SCALE_V) ? FULL_SCALE_V : v;
   endfunction

endpackage

[hdl/tss_if.sv]
interface tss_req_if;
   logic valid;
   logic ready;
   tss_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface tss_rsp_if;
   logic valid;
   logic ready;
   tss_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

[hdl/tss_dp.sv]
module tss_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tss_pkg::tss_cmd_type          cmd,
   output tss_pkg::tss_sts_type          sts,
   input  tss_pkg::req_word_type         req_word,
   output tss_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_we,
   input  logic [tss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tss_pkg::*;

   logic kind_ff, rec_ff;
   logic [THR_W-1:0] start_ff, end_ff, inc_ff;
   logic [TIME_W-1:0] dwell_ff, settle_ff;
   logic [1:0] mode_ff;

   logic [1:0] phase_ff, phase_in;
   logic armed_ff, armed_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] total_ff, total_in;
   logic [THR_W-1:0] target_ff, target_in;
   logic active_ff, active_in;

   req_word_type in_ff, in_in;
   logic wr_ff, wr_in, trig_ff, trig_in, stop_ff, stop_in;
   logic tmo_ff, tmo_in, pdone_ff, pdone_in, sdone_ff, sdone_in;
   logic [DVD_W-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   rsp_word_type out_ff, out_in;

   logic sweep_up;
   logic [THR_W-1:0] span;
   logic [DVD_W-1:0] dividend, shifted, rem_next, quo_next, divisor;
   logic ge;
   logic [IDX_W:0] total_sum;
   logic [TIMER_W-1:0] timer_inc;
   logic [IDX_W-1:0] idx_next;
   logic [PROD_W:0] up_sum;
   logic [THR_W-1:0] sweep_tgt;
   logic fin, dwell_ok, need_mul;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
         start_ff <= '0;
         end_ff <= '0;
         inc_ff <= THR_W'(100);
         dwell_ff <= '0;
         settle_ff <= '0;
         mode_ff <= MODE_DWELL;
         rec_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_KIND: kind_ff <= csr_wdata[0];
            CSR_THR_START: start_ff <= csr_wdata[THR_W-1:0];
            CSR_THR_END: end_ff <= csr_wdata[THR_W-1:0];
            CSR_SWEEP_INC: inc_ff <= csr_wdata[THR_W-1:0];
            CSR_DWELL: dwell_ff <= csr_wdata[TIME_W-1:0];
            CSR_SETTLE: settle_ff <= csr_wdata[TIME_W-1:0];
            CSR_MODE: mode_ff <= csr_wdata[1:0];
            CSR_REC: rec_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         armed_ff <= 1'b0;
         timer_ff <= '0;
         idx_ff <= '0;
         total_ff <= '0;
         target_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         armed_ff <= armed_in;
         timer_ff <= timer_in;
         idx_ff <= idx_in;
         total_ff <= total_in;
         target_ff <= target_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      wr_ff <= wr_in;
      trig_ff <= trig_in;
      stop_ff <= stop_in;
      tmo_ff <= tmo_in;
      pdone_ff <= pdone_in;
      sdone_ff <= sdone_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      out_ff <= out_in;
   end

   // shared arithmetic
   always_comb begin
      sweep_up = end_ff > start_ff;
      span = sweep_up ? (end_ff - start_ff) : (start_ff - end_ff);
      dividend = {1'b0, span, 1'b0} + {2'b00, inc_ff};
      divisor = {1'b0, inc_ff, 1'b0};
      shifted = {rem_ff[DVD_W-2:0], quo_ff[DVD_W-1]};
      ge = shifted >= divisor;
      rem_next = ge ? (shifted - divisor) : shifted;
      quo_next = {quo_ff[DVD_W-2:0], ge};
      total_sum = {1'b0, quo_next} + (IDX_W+1)'(1);
      timer_inc = (timer_ff == TIMER_MAX) ? timer_ff : (timer_ff + TIMER_W'(1));
      idx_next = (idx_ff == IDX_MAX) ? idx_ff : (idx_ff + IDX_W'(1));
      up_sum = {{(PROD_W+1-THR_W){1'b0}}, start_ff} + {1'b0, prod_ff};
      if (sweep_up) begin
         sweep_tgt = (up_sum > (PROD_W+1)'(FULL_SCALE)) ? FULL_SCALE_V : up_sum[THR_W-1:0];
      end else if (prod_ff > {{(PROD_W-THR_W){1'b0}}, start_ff}) begin
         sweep_tgt = '0;
      end else begin
         sweep_tgt = clamp_fs(start_ff - prod_ff[THR_W-1:0]);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      armed_in = armed_ff;
      timer_in = timer_ff;
      idx_in = idx_ff;
      total_in = total_ff;
      target_in = target_ff;
      active_in = active_ff;
      in_in = in_ff;
      wr_in = wr_ff;
      trig_in = trig_ff;
      stop_in = stop_ff;
      tmo_in = tmo_ff;
      pdone_in = pdone_ff;
      sdone_in = sdone_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      out_in = out_ff;
      fin = 1'b0;
      dwell_ok = 1'b0;
      need_mul = 1'b0;

      if (cmd.latch) begin
         in_in = req_word;
      end

      if (cmd.exec) begin
         wr_in = 1'b0;
         trig_in = 1'b0;
         stop_in = 1'b0;
         tmo_in = 1'b0;
         pdone_in = 1'b0;
         sdone_in = 1'b0;
         if (in_ff.cmd == CMD_START) begin
            phase_in = PH_WAIT;
            armed_in = 1'b0;
            timer_in = '0;
            idx_in = '0;
            active_in = 1'b1;
            wr_in = 1'b1;
            total_in = IDX_W'(1);
            if (kind_ff == KIND_HOLD) begin
               target_in = clamp_fs(end_ff);
            end else begin
               target_in = clamp_fs(start_ff);
               rem_in = '0;
               quo_in = dividend;
               cnt_in = '0;
            end
         end else if (active_ff) begin
            case (phase_ff)
               PH_WAIT: begin
                  if (!armed_ff) begin
                     armed_in = 1'b1;
                     timer_in = '0;
                  end else begin
                     timer_in = timer_inc;
                     if (in_ff.motor_at_target) begin
                        phase_in = PH_SETTLE;
                        timer_in = '0;
                     end else if (timer_inc > WAIT_TIMEOUT_V) begin
                        phase_in = PH_SETTLE;
                        timer_in = '0;
                        tmo_in = 1'b1;
                     end
                  end
               end
               PH_SETTLE: begin
                  timer_in = timer_inc;
                  if (timer_inc >= {1'b0, settle_ff}) begin
                     trig_in = rec_ff;
                     phase_in = PH_MEASURE;
                     timer_in = '0;
                  end
               end
               PH_MEASURE: begin
                  timer_in = timer_inc;
                  dwell_ok = timer_inc >= {1'b0, dwell_ff};
                  if (rec_ff && mode_ff == MODE_WINDOW) begin
                     fin = !in_ff.recorder_busy;
                  end else begin
                     fin = dwell_ok;
                     stop_in = dwell_ok && rec_ff && mode_ff == MODE_DWELL;
                  end
                  if (fin) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
            if (fin) begin
               pdone_in = 1'b1;
               if (kind_ff == KIND_HOLD) begin
                  sdone_in = 1'b1;
                  active_in = 1'b0;
               end else begin
                  idx_in = idx_next;
                  if (idx_next >= total_ff) begin
                     target_in = clamp_fs(end_ff);
                     sdone_in = 1'b1;
                     active_in = 1'b0;
                  end else begin
                     need_mul = 1'b1;
                  end
               end
            end
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_next;
         quo_in = quo_next;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == DIV_LAST) begin
            total_in = total_sum[IDX_W] ? IDX_MAX : total_sum[IDX_W-1:0];
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(inc_ff) * PROD_W'(idx_ff);
      end

      if (cmd.upd) begin
         target_in = sweep_tgt;
         phase_in = PH_WAIT;
         armed_in = 1'b0;
         timer_in = '0;
         wr_in = 1'b1;
      end

      if (cmd.load_out) begin
         out_in.throttle_cmd = target_ff;
         out_in.throttle_write = wr_ff;
         out_in.phase_now = phase_ff;
         out_in.trigger_measure = trig_ff;
         out_in.stop_recorder = stop_ff;
         out_in.wait_timed_out = tmo_ff;
         out_in.point_done = pdone_ff;
         out_in.step_done = sdone_ff;
         out_in.point_number = idx_ff;
      end
   end

   assign sts.need_div = in_ff.cmd == CMD_START && kind_ff != KIND_HOLD && inc_ff != '0;
   assign sts.need_mul = need_mul;
   assign sts.div_last = cnt_ff == DIV_LAST;
   assign rsp_word = out_ff;

endmodule

[hdl/tss_ctrl.sv]
module tss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tss_pkg::tss_cmd_type cmd,
   input  tss_pkg::tss_sts_type sts
);
   import tss_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV = 3'd2;
   localparam logic [2:0] S_MUL = 3'd3;
   localparam logic [2:0] S_UPD = 3'd4;
   localparam logic [2:0] S_FIN = 3'd5;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_div) begin
               state_in = S_DIV;
            end else if (sts.need_mul) begin
               state_in = S_MUL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIN;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/throttle_step_sweep_sequencer.sv]
// Thrust stand step sequencer. Each word on the request channel is either a one millisecond
// tick or a start command, and each gives exactly one response word. Words are handled one
// at a time: a tick is latched, executed and then loaded into the response register, a tick
// that moves a sweep to its next point also passes through a multiply step and an add/clamp
// step, and the start of a sweep with a nonzero increment also runs the 16-step restoring
// divider that works out the point count one quotient bit per cycle. The next request is
// taken in the cycle after the response register is loaded, even while that response waits
// for rsp_chan.ready; a response not yet taken holds the following one back in the last
// step. Configuration writes through the csr_ port take effect on the next cycle and are
// meant to be done only while no word is in flight.
module throttle_step_sweep_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   tss_req_if.sink                        req_chan,
   tss_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [tss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tss_pkg::*;

   tss_cmd_type cmd;
   tss_sts_type sts;
   logic req_ready;
   logic rsp_valid;
   rsp_word_type rsp_word;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tss_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_chan.word),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.word = rsp_word;

endmodule

[hdl/tss_chk.sv]
module tss_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input tss_pkg::rsp_word_type       rsp_word
);
   import tss_pkg::*;

   // a waiting response word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before taken");

   a_step_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.step_done |-> rsp_word.point_done)
      else $error("step done without point done");

   a_tmo_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.wait_timed_out |-> rsp_word.phase_now == PH_SETTLE)
      else $error("timeout outside settle phase");

   a_trig_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.trigger_measure |-> rsp_word.phase_now == PH_MEASURE)
      else $error("trigger outside measure phase");

   a_stop_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.stop_recorder |-> rsp_word.point_done)
      else $error("recorder stop without point done");

endmodule

bind throttle_step_sweep_sequencer tss_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.word)
);

[test/testbench.sv]
module testbench;
   import tss_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic CMD_TICK = ~CMD_START;

   typedef struct packed {
      logic is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] data;
      req_word_type w;
      logic lit;
      rsp_word_type r;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tss_req_if req_if ();
   tss_rsp_if rsp_if ();

   throttle_step_sweep_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register mirror
   logic cfg_kind;
   logic [THR_W-1:0] cfg_start;
   logic [THR_W-1:0] cfg_end;
   logic [THR_W-1:0] cfg_inc;
   logic [TIME_W-1:0] cfg_dwell;
   logic [TIME_W-1:0] cfg_settle;
   logic [1:0] cfg_mode;
   logic cfg_rec;

   // sequencer state
   logic [1:0] st_phase;
   logic st_armed;
   logic [TIMER_W-1:0] st_timer;
   logic [IDX_W-1:0] st_index;
   logic [IDX_W-1:0] st_total;
   logic [THR_W-1:0] st_throttle;
   logic st_active;

   rsp_word_type awaited_rsp[$];
   stim_row_type plan[$];
   int unsigned mismatch_count;
   int unsigned random_items;
   int unsigned cycle_count;
   int unsigned stall_left;
   int unsigned step_no;
   bit idle_en;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [THR_W-1:0] fit_scale(longint v);
      if (v < 0) return '0;
      if (v > longint'(FULL_SCALE)) return THR_W'(FULL_SCALE);
      return v[THR_W-1:0];
   endfunction

   function automatic rsp_word_type advance_sequencer(req_word_type w);
      rsp_word_type r;
      logic finished;
      logic dwell_ok;
      int unsigned span;
      int unsigned cnt;
      longint off;
      longint tgt;
      r = '0;
      finished = 1'b0;
      if (w.cmd == CMD_START) begin
         st_phase = PH_WAIT;
         st_armed = 1'b0;
         st_timer = '0;
         st_index = '0;
         if (cfg_kind == KIND_HOLD) begin
            st_total = IDX_W'(1);
            st_throttle = fit_scale(longint'(cfg_end));
         end else begin
            span = (cfg_end > cfg_start) ? 32'(cfg_end - cfg_start)
                                         : 32'(cfg_start - cfg_end);
            cnt = 1;
            if (cfg_inc != 0) begin
               cnt = (2 * span + 32'(cfg_inc)) / (2 * 32'(cfg_inc)) + 1;
               if (cnt > 65535) cnt = 65535;
            end
            st_total = cnt[IDX_W-1:0];
            st_throttle = fit_scale(longint'(cfg_start));
         end
         st_active = 1'b1;
         r.throttle_write = 1'b1;
      end else if (st_active) begin
         case (st_phase)
            PH_WAIT: begin
               if (!st_armed) begin
                  st_armed = 1'b1;
                  st_timer = '0;
               end else begin
                  if (st_timer != '1) st_timer++;
                  if (w.motor_at_target) begin
                     st_phase = PH_SETTLE;
                     st_timer = '0;
                  end else if (st_timer > TIMER_W'(WAIT_TIMEOUT)) begin
                     st_phase = PH_SETTLE;
                     st_timer = '0;
                     r.wait_timed_out = 1'b1;
                  end
               end
            end
            PH_SETTLE: begin
               if (st_timer != '1) st_timer++;
               if (st_timer >= {1'b0, cfg_settle}) begin
                  r.trigger_measure = cfg_rec;
                  st_phase = PH_MEASURE;
                  st_timer = '0;
               end
            end
            PH_MEASURE: begin
               if (st_timer != '1) st_timer++;
               dwell_ok = (st_timer >= {1'b0, cfg_dwell});
               if (cfg_rec && cfg_mode == MODE_WINDOW) begin
                  finished = !w.recorder_busy;
               end else begin
                  finished = dwell_ok;
                  if (dwell_ok && cfg_rec && cfg_mode == MODE_DWELL) r.stop_recorder = 1'b1;
               end
               if (finished) st_phase = PH_DONE;
            end
            default: finished = 1'b1;
         endcase
         if (finished) begin
            r.point_done = 1'b1;
            if (cfg_kind == KIND_HOLD) begin
               r.step_done = 1'b1;
               st_active = 1'b0;
            end else begin
               if (st_index != '1) st_index++;
               if (st_index >= st_total) begin
                  st_throttle = fit_scale(longint'(cfg_end));
                  r.step_done = 1'b1;
                  st_active = 1'b0;
               end else begin
                  off = longint'(cfg_inc) * longint'(st_index);
                  tgt = (cfg_end > cfg_start) ? longint'(cfg_start) + off
                                              : longint'(cfg_start) - off;
                  st_throttle = fit_scale(tgt);
                  st_phase = PH_WAIT;
                  st_armed = 1'b0;
                  st_timer = '0;
                  r.throttle_write = 1'b1;
               end
            end
         end
      end
      r.throttle_cmd = st_throttle;
      r.phase_now = st_phase;
      r.point_number = st_index;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      stim_row_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.idx = idx;
      s.data = data;
      return s;
   endfunction

   function automatic stim_row_type word_row(logic c, logic at, logic busy);
      stim_row_type s;
      s = '0;
      s.w = req_word_type'{c, at, busy};
      return s;
   endfunction

   function automatic stim_row_type lit_row(logic c, logic at, logic busy, rsp_word_type r);
      stim_row_type s;
      s = word_row(c, at, busy);
      s.lit = 1'b1;
      s.r = r;
      return s;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_junk(int unsigned v,
                                                       logic [CSR_DATA_W-1:0] keep);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(0, 7) == 0) ? CSR_DATA_W'($urandom) : '0;
      return (CSR_DATA_W'(v) & keep) | (junk & ~keep);
   endfunction

   function automatic int unsigned pick_throttle();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return FULL_SCALE;
         2: return $urandom_range(FULL_SCALE + 1, 16383);
         default: return $urandom_range(0, FULL_SCALE);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_if.valid = 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_STEP_KIND: cfg_kind = data[0];
         CSR_THR_START: cfg_start = data[THR_W-1:0];
         CSR_THR_END: cfg_end = data[THR_W-1:0];
         CSR_SWEEP_INC: cfg_inc = data[THR_W-1:0];
         CSR_DWELL: cfg_dwell = data[TIME_W-1:0];
         CSR_SETTLE: cfg_settle = data[TIME_W-1:0];
         CSR_MODE: cfg_mode = data[1:0];
         CSR_REC: cfg_rec = data[0];
         default: ;
      endcase
   endtask

   task automatic send_word(req_word_type w, bit counted, bit has_lit, rsp_word_type lit);
      rsp_word_type predicted;
      idle_en = (random_items < 600) && ((random_items / 50) % 4 != 3);
      @(negedge clock);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.word = w;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = advance_sequencer(w);
      awaited_rsp.push_back(has_lit ? lit : predicted);
      if (counted) random_items++;
   endtask

   task automatic random_step(bit long_wait);
      int unsigned a;
      int unsigned b;
      int unsigned d;
      int unsigned inc;
      int unsigned cap;
      int unsigned ticks;
      req_word_type w;
      a = pick_throttle();
      b = pick_throttle();
      d = (a > b) ? a - b : b - a;
      case ($urandom_range(0, 15))
         0: inc = 0;
         1: inc = 16383;
         2: inc = $urandom_range(1, 16383);
         default: begin
            inc = d / $urandom_range(1, 5) + $urandom_range(0, 40);
            if (inc == 0) inc = 1;
         end
      endcase
      write_reg(CSR_STEP_KIND,
                with_junk(long_wait ? KIND_HOLD : $urandom_range(0, 1), 16'h0001));
      write_reg(CSR_THR_START, with_junk(a, 16'h3FFF));
      write_reg(CSR_THR_END, with_junk(b, 16'h3FFF));
      write_reg(CSR_SWEEP_INC, with_junk(inc, 16'h3FFF));
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 15))
            0: d = long_wait ? 2 : 65535;
            1: d = $urandom_range(5, 40);
            default: d = $urandom_range(0, 3);
         endcase
         write_reg(i == 0 ? CSR_DWELL : CSR_SETTLE, with_junk(d, 16'hFFFF));
      end
      write_reg(CSR_MODE, with_junk($urandom_range(0, 3), 16'h0003));
      write_reg(CSR_REC, with_junk($urandom_range(0, 1), 16'h0001));

      w = req_word_type'{CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
      send_word(w, 1'b1, 1'b0, '0);
      cap = long_wait ? 2300 : 90;
      ticks = 0;
      while (st_active && ticks < cap) begin
         w.cmd = (!long_wait && $urandom_range(0, 49) == 0) ? CMD_START : CMD_TICK;
         w.motor_at_target = long_wait ? 1'b0 : 1'($urandom_range(0, 1));
         w.recorder_busy = 1'($urandom_range(0, 1));
         send_word(w, !long_wait, 1'b0, '0);
         ticks++;
      end
      // idle ticks after the step
      repeat ($urandom_range(0, 2)) begin
         w = req_word_type'{CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
         send_word(w, 1'b0, 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready = 1'b1;
         if (idle_en && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = rsp_if.word;
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response word %h", got);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.throttle_cmd !== want.throttle_cmd ||
                got.throttle_write !== want.throttle_write ||
                got.phase_now !== want.phase_now ||
                got.trigger_measure !== want.trigger_measure ||
                got.stop_recorder !== want.stop_recorder ||
                got.wait_timed_out !== want.wait_timed_out ||
                got.point_done !== want.point_done ||
                got.step_done !== want.step_done ||
                got.point_number !== want.point_number) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("mismatch (expected/actual): throttle %0d/%0d write %b/%b",
                         want.throttle_cmd, got.throttle_cmd,
                         want.throttle_write, got.throttle_write);
                  $write(" phase %0d/%0d trig %b/%b stop %b/%b tmo %b/%b",
                         want.phase_now, got.phase_now,
                         want.trigger_measure, got.trigger_measure,
                         want.stop_recorder, got.stop_recorder,
                         want.wait_timed_out, got.wait_timed_out);
                  $display(" pdone %b/%b sdone %b/%b point %0d/%0d",
                           want.point_done, got.point_done,
                           want.step_done, got.step_done,
                           want.point_number, got.point_number);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.word = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      random_items = 0;
      cycle_count = 0;
      stall_left = 0;
      step_no = 0;
      idle_en = 1'b1;
      cfg_kind = KIND_HOLD;
      cfg_start = '0;
      cfg_end = '0;
      cfg_inc = THR_W'(100);
      cfg_dwell = '0;
      cfg_settle = '0;
      cfg_mode = MODE_DWELL;
      cfg_rec = 1'b0;
      st_phase = PH_WAIT;
      st_armed = 1'b0;
      st_timer = '0;
      st_index = '0;
      st_total = '0;
      st_throttle = '0;
      st_active = 1'b0;

      // idle tick after reset, then a clamped hold step with the recorder
      plan.push_back(lit_row(CMD_TICK, 1'b1, 1'b1,
         rsp_word_type'{THR_W'(0), 1'b0, PH_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
      plan.push_back(csr_row(CSR_THR_END, 16'h3FFF));
      plan.push_back(csr_row(CSR_REC, 16'd1));
      plan.push_back(lit_row(CMD_START, 1'b0, 1'b0,
         rsp_word_type'{FULL_SCALE_V, 1'b1, PH_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
      plan.push_back(lit_row(CMD_TICK, 1'b0, 1'b0,
         rsp_word_type'{FULL_SCALE_V, 1'b0, PH_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
      plan.push_back(lit_row(CMD_TICK, 1'b1, 1'b0,
         rsp_word_type'{FULL_SCALE_V, 1'b0, PH_SETTLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
      plan.push_back(lit_row(CMD_TICK, 1'b0, 1'b1,
         rsp_word_type'{FULL_SCALE_V, 1'b0, PH_MEASURE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));
      plan.push_back(lit_row(CMD_TICK, 1'b0, 1'b0,
         rsp_word_type'{FULL_SCALE_V, 1'b0, PH_DONE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0}));
      plan.push_back(lit_row(CMD_TICK, 1'b1, 1'b1,
         rsp_word_type'{FULL_SCALE_V, 1'b0, PH_DONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}));

      // falling sweep that overshoots below zero, recorder window mode, then a restart
      plan.push_back(csr_row(CSR_STEP_KIND, 16'd1));
      plan.push_back(csr_row(CSR_THR_START, 16'd150));
      plan.push_back(csr_row(CSR_THR_END, 16'd0));
      plan.push_back(csr_row(CSR_SWEEP_INC, 16'd100));
      plan.push_back(csr_row(CSR_SETTLE, 16'd1));
      plan.push_back(csr_row(CSR_DWELL, 16'd2));
      plan.push_back(csr_row(CSR_MODE, 16'(MODE_WINDOW)));
      plan.push_back(word_row(CMD_START, 1'b1, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b1, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b0));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b0));
      plan.push_back(word_row(CMD_TICK, 1'b1, 1'b0));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b0));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b0));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b1, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b1));
      plan.push_back(word_row(CMD_START, 1'b0, 1'b0));
      plan.push_back(word_row(CMD_TICK, 1'b0, 1'b0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_reg(plan[i].idx, plan[i].data);
         else send_word(plan[i].w, 1'b0, plan[i].lit, plan[i].r);
      end

      while (random_items < 700) begin
         random_step(step_no == 2);
         step_no++;
      end

      @(negedge clock);
      req_if.valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
